// ===== rtl/weighted_centroid_q16_top_assert.svh =====
// Assertion macros shared by the weighted centroid RTL.
// Included by modules that check their own logic; no other dependencies.
`ifndef WEIGHTED_CENTROID_Q16_TOP_ASSERT_SVH
`define WEIGHTED_CENTROID_Q16_TOP_ASSERT_SVH

// ante implies cons in the same cycle
`define WCQ_ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("wcq assertion failed");

// ante implies cons in the next cycle
`define WCQ_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("wcq assertion failed");

// expr never true
`define WCQ_ASSERT_NEVER(label, clk, rstn, expr) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error("wcq assertion failed");

`endif

// ===== rtl/wcq_pkg.sv =====
// Shared constants, types and helpers for the weighted centroid block.
// No dependencies; imported by every module of the block.
package wcq_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int Q_SHIFT    = 16;

    localparam int PIX_W  = 16;
    localparam int SIZE_W = 9;
    localparam int WSUM_W = 32;
    localparam int MOM_W  = 40;
    localparam int CXY_W  = 24;

    localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

    localparam int DIVD_W    = MOM_W + Q_SHIFT;
    localparam int DIV_CNT_W = $clog2(DIVD_W);

    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int OUT_DATA_W = CXY_W + CXY_W + WSUM_W;

    localparam logic [SIZE_W-1:0] WIDTH_RESET  = SIZE_W'(72);
    localparam logic [SIZE_W-1:0] HEIGHT_RESET = SIZE_W'(40);

    typedef enum logic {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic [COL_W-1:0] last_col;
        logic [ROW_W-1:0] last_row;
    } frame_cfg_t;

    typedef struct packed {
        logic [WSUM_W-1:0] weight;
        logic [MOM_W-1:0]  mom_x;
        logic [MOM_W-1:0]  mom_y;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

    // size register to last index: zero counts as one, saturates at limit
    function automatic int last_index(input logic [SIZE_W-1:0] size, input int limit);
        int v;
        v = int'(size);
        if (v == 0) begin
            return 0;
        end
        if (v > limit) begin
            return limit - 1;
        end
        return v - 1;
    endfunction

endpackage

// ===== rtl/wcq_front.sv =====
// Front end: raster counters and per-frame weight and moment accumulators.
// Depends on wcq_pkg; pushes one job per frame into wcq_fifo.
module wcq_front import wcq_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [PIX_W-1:0]  s_tdata,   // [15:0] pixel_value
    input  frame_cfg_t        cfg,
    input  fifo_stat_t        q_stat,
    output logic              push,
    output job_t              push_job
);

    logic [COL_W-1:0]       col_reg;
    logic [ROW_W-1:0]       row_reg;
    logic [WSUM_W-1:0]      wsum_reg;
    logic [MOM_W-1:0]       momx_reg;
    logic [MOM_W-1:0]       momy_reg;

    logic                   row_end;
    logic                   frame_end;
    logic                   accept;
    logic [PIX_W+COL_W-1:0] prod_x;
    logic [PIX_W+ROW_W-1:0] prod_y;
    logic [WSUM_W-1:0]      wsum_next;
    logic [MOM_W-1:0]       momx_next;
    logic [MOM_W-1:0]       momy_next;

    // a counter past a shrunken size also ends its row or frame
    assign row_end   = (col_reg >= cfg.last_col);
    assign frame_end = row_end && (row_reg >= cfg.last_row);

    // only the last pixel of a frame needs room in the queue
    assign s_tready = !(frame_end && q_stat.full);
    assign accept   = s_tvalid && s_tready;

    assign prod_x    = (PIX_W+COL_W)'(s_tdata) * (PIX_W+COL_W)'(col_reg);
    assign prod_y    = (PIX_W+ROW_W)'(s_tdata) * (PIX_W+ROW_W)'(row_reg);
    assign wsum_next = wsum_reg + WSUM_W'(s_tdata);
    assign momx_next = momx_reg + MOM_W'(prod_x);
    assign momy_next = momy_reg + MOM_W'(prod_y);

    assign push            = accept && frame_end;
    assign push_job.weight = wsum_next;
    assign push_job.mom_x  = momx_next;
    assign push_job.mom_y  = momy_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg  <= '0;
            row_reg  <= '0;
            wsum_reg <= '0;
            momx_reg <= '0;
            momy_reg <= '0;
        end else if (accept) begin
            if (frame_end) begin
                col_reg  <= '0;
                row_reg  <= '0;
                wsum_reg <= '0;
                momx_reg <= '0;
                momy_reg <= '0;
            end else begin
                wsum_reg <= wsum_next;
                momx_reg <= momx_next;
                momy_reg <= momy_next;
                if (row_end) begin
                    col_reg <= '0;
                    row_reg <= row_reg + ROW_W'(1);
                end else begin
                    col_reg <= col_reg + COL_W'(1);
                end
            end
        end
    end

endmodule

// ===== rtl/wcq_fifo.sv =====
// Short job queue between the accumulating front end and the divider.
// Depends on wcq_pkg and the assertion macro header.
`include "weighted_centroid_q16_top_assert.svh"

module wcq_fifo import wcq_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push,
    input  job_t       push_job,
    input  logic       pop,
    output job_t       pop_job,
    output fifo_stat_t stat
);

    job_t                  mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_CNT_W-1:0] cnt_reg;
    logic                  do_push;
    logic                  do_pop;

    assign stat.full  = (cnt_reg == FIFO_CNT_W'(FIFO_DEPTH));
    assign stat.empty = (cnt_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign pop_job    = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1)) ?
                              '0 : wr_ptr_reg + FIFO_PTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1)) ?
                              '0 : rd_ptr_reg + FIFO_PTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   cnt_reg <= cnt_reg + FIFO_CNT_W'(1);
                2'b01:   cnt_reg <= cnt_reg - FIFO_CNT_W'(1);
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

    `WCQ_ASSERT_NEVER(a_no_push_when_full, aclk, aresetn, push && stat.full)
    `WCQ_ASSERT_NEVER(a_cnt_in_range, aclk, aresetn, cnt_reg > FIFO_CNT_W'(FIFO_DEPTH))

endmodule

// ===== rtl/wcq_back.sv =====
// Back end: bit-serial restoring divider for both Q16 means and the
// result register. Depends on wcq_pkg and the assertion macro header.
`include "weighted_centroid_q16_top_assert.svh"

module wcq_back import wcq_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  job_t                  pop_job,
    input  fifo_stat_t            q_stat,
    output logic                  pop,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,  // [23:0] centroid_x, [47:24] centroid_y,
                                            // [79:48] total_weight
    output logic                  m_tuser   // [0] found
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV_X,
        ST_DIV_Y,
        ST_HOLD
    } state_t;

    state_t                 state_reg;
    logic [DIV_CNT_W-1:0]   cnt_reg;
    logic [WSUM_W:0]        rem_reg;
    logic [DIVD_W-1:0]      quo_reg;
    logic [WSUM_W-1:0]      div_reg;
    logic [MOM_W-1:0]       momy_reg;
    logic [CXY_W-1:0]       qx_reg;
    logic [CXY_W-1:0]       qy_reg;
    logic                   found_reg;

    logic                   m_valid_reg;
    logic [CXY_W-1:0]       ox_reg;
    logic [CXY_W-1:0]       oy_reg;
    logic [WSUM_W-1:0]      ow_reg;
    logic                   of_reg;

    logic [WSUM_W:0]        trial;
    logic                   ge;
    logic [WSUM_W:0]        rem_step;
    logic [DIVD_W-1:0]      quo_step;
    logic                   out_free;

    // one quotient bit per cycle; remainder stays below the divisor
    assign trial    = {rem_reg[WSUM_W-1:0], quo_reg[DIVD_W-1]};
    assign ge       = (trial >= {1'b0, div_reg});
    assign rem_step = ge ? (trial - {1'b0, div_reg}) : trial;
    assign quo_step = {quo_reg[DIVD_W-2:0], ge};

    assign out_free = !m_valid_reg || m_tready;
    assign pop      = (state_reg == ST_IDLE) && !q_stat.empty;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {ow_reg, oy_reg, ox_reg};
    assign m_tuser  = of_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_tready && !((state_reg == ST_HOLD) && out_free)) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (!q_stat.empty) begin
                        div_reg  <= pop_job.weight;
                        momy_reg <= pop_job.mom_y;
                        rem_reg  <= '0;
                        quo_reg  <= {pop_job.mom_x, {Q_SHIFT{1'b0}}};
                        cnt_reg  <= DIV_CNT_W'(DIVD_W - 1);
                        if (pop_job.weight == '0) begin
                            qx_reg    <= '0;
                            qy_reg    <= '0;
                            found_reg <= 1'b0;
                            state_reg <= ST_HOLD;
                        end else begin
                            found_reg <= 1'b1;
                            state_reg <= ST_DIV_X;
                        end
                    end
                end
                ST_DIV_X: begin
                    if (cnt_reg == '0) begin
                        qx_reg    <= quo_step[CXY_W-1:0];
                        rem_reg   <= '0;
                        quo_reg   <= {momy_reg, {Q_SHIFT{1'b0}}};
                        cnt_reg   <= DIV_CNT_W'(DIVD_W - 1);
                        state_reg <= ST_DIV_Y;
                    end else begin
                        rem_reg <= rem_step;
                        quo_reg <= quo_step;
                        cnt_reg <= cnt_reg - DIV_CNT_W'(1);
                    end
                end
                ST_DIV_Y: begin
                    rem_reg <= rem_step;
                    quo_reg <= quo_step;
                    cnt_reg <= cnt_reg - DIV_CNT_W'(1);
                    if (cnt_reg == '0) begin
                        qy_reg    <= quo_step[CXY_W-1:0];
                        state_reg <= ST_HOLD;
                    end
                end
                ST_HOLD: begin
                    if (out_free) begin
                        ox_reg      <= qx_reg;
                        oy_reg      <= qy_reg;
                        ow_reg      <= div_reg;
                        of_reg      <= found_reg;
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    `WCQ_ASSERT_IMPLY(a_div_nonzero, aclk, aresetn,
        (state_reg == ST_DIV_X) || (state_reg == ST_DIV_Y), div_reg != '0)
    `WCQ_ASSERT_IMPLY(a_empty_frame_zero, aclk, aresetn,
        m_valid_reg && !of_reg, (ox_reg == '0) && (oy_reg == '0) && (ow_reg == '0))
    `WCQ_ASSERT_NEXT(a_hold_loads_output, aclk, aresetn,
        (state_reg == ST_HOLD) && out_free, m_valid_reg && (state_reg == ST_IDLE))

endmodule

// ===== rtl/weighted_centroid_q16_top.sv =====
// Intensity-weighted centroid, top level: frame size registers on an APB port,
// front accumulator, job queue and serial divider. Depends on wcq_pkg and all wcq_* modules.
//
// Pixels stream in raster order at one per cycle while s_tready is high; the
// frame size comes from frame_width (0x0) and frame_height (0x4). After the last
// pixel of each frame the block returns one result: the weighted mean column and
// row in unsigned Q16, the total weight, and found in m_tuser (clear, with zero
// data, for an all-zero frame). For each result the back end loads the job, runs
// its one-bit-per-cycle divider for each coordinate in turn and then loads the
// output register; an all-zero frame skips the divider. A two-entry queue holds
// finished frame sums, so division overlaps the next frame; s_tready drops only
// on a frame's last pixel while that queue is full, which happens when frames are
// shorter than the divide time or the result side stalls.
module weighted_centroid_q16_top import wcq_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [PIX_W-1:0]      s_tdata,   // [15:0] pixel_value
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // [23:0] centroid_x, [47:24] centroid_y,
                                             // [79:48] total_weight
    output logic                  m_tuser,   // [0] found
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [SIZE_W-1:0] width_reg;
    logic [SIZE_W-1:0] height_reg;
    reg_idx_t          reg_idx;
    frame_cfg_t        cfg;
    fifo_stat_t        q_stat;
    logic              push;
    logic              pop;
    job_t              push_job;
    job_t              pop_job;

    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end else if (psel && penable && pwrite && pready) begin
            case (reg_idx)
                REG_FRAME_WIDTH:  width_reg  <= pwdata[SIZE_W-1:0];
                REG_FRAME_HEIGHT: height_reg <= pwdata[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_FRAME_WIDTH:  prdata = APB_DATA_W'(width_reg);
            REG_FRAME_HEIGHT: prdata = APB_DATA_W'(height_reg);
            default:          prdata = '0;
        endcase
    end

    assign cfg.last_col = COL_W'(last_index(width_reg, MAX_WIDTH));
    assign cfg.last_row = ROW_W'(last_index(height_reg, MAX_HEIGHT));

    wcq_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .cfg      (cfg),
        .q_stat   (q_stat),
        .push     (push),
        .push_job (push_job)
    );

    wcq_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .pop_job  (pop_job),
        .stat     (q_stat)
    );

    wcq_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .pop_job  (pop_job),
        .q_stat   (q_stat),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for weighted_centroid_q16_top: raster frames in, centroids out.
// Depends on wcq_pkg and the block's RTL; computes expected centroids itself, apart from typed table rows.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import wcq_pkg::*;

    localparam int DRAIN_CYCLES = 120;
    localparam int HOLD_CYCLES  = 800;
    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int PHASE_PIXELS = 340;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        logic [CXY_W-1:0]  cx;
        logic [CXY_W-1:0]  cy;
        logic [WSUM_W-1:0] weight;
        logic              found;
    } frame_result_t;

    typedef struct {
        bit              resize;
        logic [31:0]     w_word;
        logic [31:0]     h_word;
        logic [PIX_W-1:0] pix;
        bit              typed;
        frame_result_t   res;
    } dir_row_t;

    typedef enum int {
        PAT_RANDOM,
        PAT_ZERO,
        PAT_FULL,
        PAT_SPARSE,
        PAT_DIM,
        PAT_CORNER
    } pixel_pattern_t;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [PIX_W-1:0]      s_tdata;   // [15:0] pixel_value
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;   // [23:0] centroid_x, [47:24] centroid_y,
                                      // [79:48] total_weight
    logic                  m_tuser;   // [0] found
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // predictor copy of the block's registers and accumulators
    logic [SIZE_W-1:0] size_w;
    logic [SIZE_W-1:0] size_h;
    logic [7:0]        col_pos;
    logic [7:0]        row_pos;
    logic [WSUM_W-1:0] wsum;
    logic [MOM_W-1:0]  xmom;
    logic [MOM_W-1:0]  ymom;
    frame_result_t     pending_centroids[$];

    int send_idle_pct = 0;
    int stall_pct = 0;
    int hold_reqs = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int mismatches = 0;
    int pixels_sent = 0;
    int results_checked = 0;
    int size_settings = 0;

    int send_idle_mix[4] = '{0, 85, 0, 31};
    int stall_mix[4]     = '{0, 0, 85, 31};

    // reset size is 72x40; rows with typed results are 1x1 or 2x2 frames
    dir_row_t dir_rows[18] = '{
        '{0, 32'h0, 32'h0, 16'h0001, 0, '0},
        '{0, 32'h0, 32'h0, 16'hFFFF, 0, '0},
        '{0, 32'h0, 32'h0, 16'h8000, 0, '0},
        // shrink mid-frame: column 3 is past the new last column, frame closes
        '{1, 32'd2, 32'd1, 16'h0010, 0, '0},
        '{1, 32'hFFFF_FE01, 32'hFFFF_FE01, 16'h0000, 1, '{24'h0, 24'h0, 32'h0, 1'b0}},
        '{0, 32'h0, 32'h0, 16'hFFFF, 1, '{24'h0, 24'h0, 32'h0000_FFFF, 1'b1}},
        '{1, 32'd0, 32'd0, 16'h1234, 1, '{24'h0, 24'h0, 32'h0000_1234, 1'b1}},
        '{1, 32'd2, 32'd2, 16'h0000, 0, '0},
        '{0, 32'h0, 32'h0, 16'h0000, 0, '0},
        '{0, 32'h0, 32'h0, 16'h0000, 0, '0},
        '{0, 32'h0, 32'h0, 16'hFFFF, 1, '{24'h01_0000, 24'h01_0000, 32'h0000_FFFF, 1'b1}},
        '{0, 32'h0, 32'h0, 16'hFFFF, 0, '0},
        '{0, 32'h0, 32'h0, 16'hFFFF, 0, '0},
        '{0, 32'h0, 32'h0, 16'hFFFF, 0, '0},
        '{0, 32'h0, 32'h0, 16'hFFFF, 1, '{24'h00_8000, 24'h00_8000, 32'h0003_FFFC, 1'b1}},
        '{1, 32'd3, 32'd1, 16'h0001, 0, '0},
        '{0, 32'h0, 32'h0, 16'h0002, 0, '0},
        '{0, 32'h0, 32'h0, 16'h0003, 0, '0}
    };

    weighted_centroid_q16_top u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #10 aclk = ~aclk;

    function automatic int eff_size(input logic [SIZE_W-1:0] v, input int lim);
        if (v == '0) begin
            return 1;
        end
        if (int'(v) > lim) begin
            return lim;
        end
        return int'(v);
    endfunction

    // one pixel into the accumulators; returns 1 when it closes a frame
    function automatic bit centroid_step(input logic [PIX_W-1:0] pix,
                                         output frame_result_t res);
        logic [DIVD_W-1:0] num_x;
        logic [DIVD_W-1:0] num_y;
        int w;
        int h;
        w = eff_size(size_w, MAX_WIDTH);
        h = eff_size(size_h, MAX_HEIGHT);
        res = '0;
        wsum = wsum + WSUM_W'(pix);
        xmom = xmom + MOM_W'(pix) * MOM_W'(col_pos);
        ymom = ymom + MOM_W'(pix) * MOM_W'(row_pos);
        if (int'(col_pos) < w - 1) begin
            col_pos = col_pos + 8'd1;
            return 1'b0;
        end
        col_pos = '0;
        if (int'(row_pos) < h - 1) begin
            row_pos = row_pos + 8'd1;
            return 1'b0;
        end
        if (wsum != '0) begin
            num_x = DIVD_W'(xmom) << Q_SHIFT;
            num_y = DIVD_W'(ymom) << Q_SHIFT;
            res.cx = CXY_W'(num_x / DIVD_W'(wsum));
            res.cy = CXY_W'(num_y / DIVD_W'(wsum));
            res.weight = wsum;
            res.found = 1'b1;
        end
        row_pos = '0;
        wsum = '0;
        xmom = '0;
        ymom = '0;
        return 1'b1;
    endfunction

    function automatic logic [31:0] size_word(input int v);
        logic [31:0] word;
        word = $urandom_range(1) ? ($urandom & 32'hFFFF_FE00) : 32'h0;
        word[SIZE_W-1:0] = SIZE_W'(v);
        return word;
    endfunction

    task automatic flag_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            $display("%s", msg);
        end
    endtask

    // called at a falling edge; returns at the falling edge after the transfer
    task automatic push_pixel(input logic [PIX_W-1:0] pix, input bit typed,
                              input frame_result_t typed_res);
        frame_result_t res;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            s_tdata  <= PIX_W'($urandom);
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pix;
        do @(posedge aclk); while (!s_tready);
        if (centroid_step(pix, res)) begin
            pending_centroids.push_back(typed ? typed_res : res);
        end
        pixels_sent++;
        @(negedge aclk);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_centroids.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        @(negedge aclk);
    endtask

    // write, then read back; only the low nine bits are kept
    task automatic set_register(input reg_idx_t idx, input logic [31:0] word);
        logic [APB_DATA_W-1:0] rd;
        rd = '0;
        for (int acc = 0; acc < 2; acc++) begin
            psel    <= 1'b1;
            pwrite  <= (acc == 0);
            penable <= 1'b0;
            paddr   <= APB_ADDR_W'(int'(idx) * 4);
            pwdata  <= (acc == 0) ? word : $urandom;
            @(negedge aclk);
            penable <= 1'b1;
            do @(posedge aclk); while (!pready);
            rd = prdata;
            @(negedge aclk);
            psel    <= 1'b0;
            penable <= 1'b0;
            @(negedge aclk);
        end
        if (rd !== APB_DATA_W'(word[SIZE_W-1:0])) begin
            flag_mismatch($sformatf("readback of %s: got %h, want %h", idx.name(), rd,
                                    APB_DATA_W'(word[SIZE_W-1:0])));
        end
    endtask

    task automatic set_frame(input logic [31:0] w_word, input logic [31:0] h_word);
        wait_idle();
        set_register(REG_FRAME_WIDTH, w_word);
        set_register(REG_FRAME_HEIGHT, h_word);
        size_w = w_word[SIZE_W-1:0];
        size_h = h_word[SIZE_W-1:0];
        size_settings++;
    endtask

    // one 256-pixel line with weight only on its far end: centroid at 255.0
    task automatic edge_frame(input int w, input int h);
        set_frame(size_word(w), size_word(h));
        for (int i = 0; i < 256; i++) begin
            push_pixel((i == 255) ? PIX_W'($urandom_range(1, 65535)) : '0, 1'b0, '0);
        end
    endtask

    task automatic random_segment();
        int pick;
        int w;
        int h;
        int area;
        int count;
        pixel_pattern_t pat;
        logic [PIX_W-1:0] pix;
        pick = $urandom_range(99);
        if (pick < 65) begin
            w = $urandom_range(1, 8);
            h = $urandom_range(1, 6);
        end else if (pick < 80) begin
            w = $urandom_range(1, 32);
            h = $urandom_range(1, 3);
        end else if (pick < 92) begin
            w = $urandom_range(0, 3);
            h = $urandom_range(0, 3);
        end else begin
            w = $urandom_range(1, 4);
            h = $urandom_range(8, 24);
        end
        set_frame(size_word(w), size_word(h));
        area = ((w == 0) ? 1 : w) * ((h == 0) ? 1 : h);
        count = $urandom_range(1, 4) * area;
        // now and then add up to a frame of pixels so the next resize may land inside a frame
        if ($urandom_range(9) == 0) begin
            count += $urandom_range(1, area);
        end
        pat = pixel_pattern_t'($urandom_range(int'(PAT_CORNER)));
        for (int i = 0; i < count; i++) begin
            case (pat)
                PAT_RANDOM: pix = PIX_W'($urandom);
                PAT_ZERO:   pix = '0;
                PAT_FULL:   pix = '1;
                PAT_SPARSE: pix = ($urandom_range(7) == 0) ? PIX_W'($urandom) : '0;
                PAT_DIM:    pix = PIX_W'($urandom_range(15));
                default: begin
                    case ($urandom_range(4))
                        0: pix = '0;
                        1: pix = '1;
                        2: pix = 16'h0001;
                        3: pix = 16'h8000;
                        default: pix = PIX_W'($urandom);
                    endcase
                end
            endcase
            push_pixel(pix, 1'b0, '0);
        end
    endtask

    // result side: random stalls plus long hold-offs requested by the sender
    always @(negedge aclk) begin
        if (hold_seen != hold_reqs) begin
            hold_seen = hold_reqs;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin : result_check
        frame_result_t got;
        frame_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tdata[23:0], m_tdata[47:24], m_tdata[79:48], m_tuser};
            if (pending_centroids.size() == 0) begin
                flag_mismatch($sformatf("unexpected result x=%h y=%h w=%h found=%b",
                                        got.cx, got.cy, got.weight, got.found));
            end else begin
                want = pending_centroids.pop_front();
                results_checked++;
                if (got !== want) begin
                    flag_mismatch($sformatf(
                        "centroid %0d: got x=%h y=%h w=%h found=%b, want x=%h y=%h w=%h found=%b",
                        results_checked, got.cx, got.cy, got.weight, got.found,
                        want.cx, want.cy, want.weight, want.found));
                end
            end
        end
    end

    initial begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("Timed out after %0d cycles, %0d results outstanding", CYCLE_LIMIT,
                 pending_centroids.size());
        $display("Regression FAIL");
        $finish;
    end

    initial begin : stimulus
        int start;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        m_tready = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        size_w   = WIDTH_RESET;
        size_h   = HEIGHT_RESET;
        col_pos  = '0;
        row_pos  = '0;
        wsum     = '0;
        xmom     = '0;
        ymom     = '0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].resize) begin
                set_frame(dir_rows[i].w_word, dir_rows[i].h_word);
            end
            push_pixel(dir_rows[i].pix, dir_rows[i].typed, dir_rows[i].res);
        end

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = send_idle_mix[ph];
            stall_pct = stall_mix[ph];
            start = pixels_sent;
            if (ph == 0) begin
                // 1x1 frames against a stalled output fill the queue and block input
                set_frame(size_word(1), size_word(1));
                hold_reqs++;
                repeat (24) push_pixel(PIX_W'($urandom), 1'b0, '0);
                edge_frame(511, 1);
            end else if (ph == 2) begin
                edge_frame(1, 300);
            end
            while (pixels_sent - start < PHASE_PIXELS) begin
                random_segment();
            end
        end

        wait_idle();
        $display("Covered %0d pixels over %0d frame sizes, %0d centroids checked",
                 pixels_sent, size_settings, results_checked);
        $display("Traffic mixes: none, sender 85%%, receiver 85%%, both 31%%, one long hold;"
                 , " %0d mismatches", mismatches);
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
